FILE: hw/rtl/circle_octant_point_generator_core_defines.svh
// Assertion macros shared by the checker files of the circle point generator.
// Each one samples on clk and is disabled while rst is high, so the file that
// uses them must have both signals in scope.
`ifndef CIRCLE_OCTANT_POINT_GENERATOR_CORE_DEFINES_SVH
`define CIRCLE_OCTANT_POINT_GENERATOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define COPG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define COPG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/copg_pkg.sv
package copg_pkg;

  // Sequencer states of the point generator.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PIVOT,
    ST_PIVSET,
    ST_LOAD,
    ST_ROOT,
    ST_ROUND,
    ST_EMIT
  } state_t;

  // Input word modes.
  localparam logic MODE_START   = 1'b0;
  localparam logic MODE_ADVANCE = 1'b1;

  // Eight symmetric points leave for every column.
  localparam int         PT_BITS    = 3;
  localparam logic [2:0] LAST_POINT = 3'd7;

endpackage

FILE: hw/rtl/circle_octant_point_generator_core.sv
// Channel | Handshake               | Payload
// item    | item_valid / item_stall | mode, centre_x, centre_y, radius
// point   | point_valid/point_stall | point_x, point_y, last_of_step, circle_done
//
// An advance word passes through the accept step, a load step, the square-root shifter
// (RADIUS_BITS + 1 root bits), a rounding step and eight point steps. A start word adds
// the radius squaring shifter (RADIUS_BITS multiplier bits), the pivot square root
// (RADIUS_BITS + 1 root bits) and a pivot set step. The square-root shifter retires one
// root bit per cycle. An advance word with no circle loaded is taken and gives no points.
// rst is synchronous and active high; it clears the sequencer and the loaded-circle flag.
// A stall on the point channel holds the point register and pauses the sequencer;
// the next input word is accepted while the eighth point still waits to be taken.
module circle_octant_point_generator_core
  import copg_pkg::*;
#(
  parameter int COORD_BITS       = 12,
  parameter int RADIUS_BITS      = 14,
  parameter int RADIUS_FRAC_BITS = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         item_valid,
  output logic                         item_stall,
  input  logic                         mode,
  input  logic signed [COORD_BITS-1:0] centre_x,
  input  logic signed [COORD_BITS-1:0] centre_y,
  input  logic        [RADIUS_BITS-1:0] radius,
  output logic                         point_valid,
  input  logic                         point_stall,
  output logic signed [COORD_BITS:0]   point_x,
  output logic signed [COORD_BITS:0]   point_y,
  output logic                         last_of_step,
  output logic                         circle_done
);

  // Root bits: the radicands (2*r^2 and 4*d) both fit in 2*ROOT_N bits.
  localparam int ROOT_N = RADIUS_BITS + 1;
  localparam int RADW   = 2 * ROOT_N;
  localparam int REMW   = ROOT_N + 2;
  // Integer bits of the radius, which bound the column and the pivot.
  localparam int INTB   = (RADIUS_BITS > RADIUS_FRAC_BITS) ?
                          (RADIUS_BITS - RADIUS_FRAC_BITS) : 1;
  localparam int YB     = INTB + 1;
  localparam int SQW    = 2 * INTB;
  localparam int SUBW   = 2 * (INTB + RADIUS_FRAC_BITS);
  localparam int R2W    = 2 * RADIUS_BITS;
  localparam int CW     = (SUBW > R2W) ? SUBW : R2W;
  localparam int OW     = COORD_BITS + 1;
  localparam int EW     = (YB + 1 > OW) ? (YB + 1) : OW;
  localparam int SUMW   = ((ROOT_N > RADIUS_FRAC_BITS) ? ROOT_N : RADIUS_FRAC_BITS) + 1;
  localparam int CNTW   = $clog2(ROOT_N + 1);
  localparam logic [SUMW-1:0] HALF_STEP = SUMW'(1) << RADIUS_FRAC_BITS;

  state_t state;
  state_t state_next;

  logic [CNTW-1:0]        cnt;
  logic [PT_BITS-1:0]     pt_idx;
  logic                   active;

  logic [COORD_BITS-1:0]  held_cx;
  logic [COORD_BITS-1:0]  held_cy;
  logic [RADIUS_BITS-1:0] mcand;
  logic [RADIUS_BITS-1:0] mpl;
  logic [R2W-1:0]         r2;
  logic [INTB-1:0]        pivot;
  logic [INTB-1:0]        column;
  logic [SQW-1:0]         col_sq;
  logic [YB-1:0]          y_off;
  logic                   col_done;

  logic [RADW-1:0]        rad;
  logic [REMW-1:0]        rem;
  logic [ROOT_N-1:0]      root;

  logic                   item_acc;
  logic                   emit_go;
  logic                   cnt_last_mul;
  logic                   cnt_last_root;

  logic [R2W-1:0]         r2_next;
  logic [REMW-1:0]        rem_shift;
  logic [REMW-1:0]        trial;
  logic                   trial_ge;
  logic [REMW-1:0]        rem_sub;
  logic [SUMW-1:0]        round_sum;
  logic [SUMW-1:0]        round_full;
  logic [CW-1:0]          r2_ext;
  logic [CW-1:0]          sub_val;
  logic [CW-1:0]          d_full;
  logic [R2W-1:0]         d_val;
  logic [SQW-1:0]         sq_inc;
  logic [EW-1:0]          cx_e;
  logic [EW-1:0]          cy_e;
  logic [EW-1:0]          x_e;
  logic [EW-1:0]          y_e;
  logic [EW-1:0]          a_e;
  logic [EW-1:0]          b_e;
  logic [EW-1:0]          px_full;
  logic [EW-1:0]          py_full;

  assign item_acc      = item_valid && !item_stall;
  assign emit_go       = (state == ST_EMIT) && (!point_valid || !point_stall);
  assign cnt_last_mul  = (cnt == CNTW'(RADIUS_BITS - 1));
  assign cnt_last_root = (cnt == CNTW'(ROOT_N - 1));

  // Squaring shifter: one multiplier bit per cycle, most significant first.
  assign r2_next = {r2[R2W-2:0], 1'b0} +
                   (mpl[RADIUS_BITS-1] ? {{(R2W-RADIUS_BITS){1'b0}}, mcand} : '0);

  // Restoring square root, two radicand bits and one root bit per cycle.
  assign rem_shift = {rem[REMW-3:0], rad[RADW-1 -: 2]};
  assign trial     = {root, 2'b01};
  assign trial_ge  = (rem_shift >= trial);
  assign rem_sub   = rem_shift - trial;

  // Round half up: (root + S) / (2 * S).
  assign round_sum  = SUMW'(root) + HALF_STEP;
  assign round_full = round_sum >> (RADIUS_FRAC_BITS + 1);

  // Radicand of the column: r^2 - (x*S)^2, clamped at zero.
  assign r2_ext  = CW'(r2);
  assign sub_val = CW'(col_sq) << (2 * RADIUS_FRAC_BITS);
  assign d_full  = r2_ext - sub_val;
  assign d_val   = (r2_ext >= sub_val) ? d_full[R2W-1:0] : '0;

  // (x+1)^2 = x^2 + 2x + 1.
  assign sq_inc = col_sq + SQW'({column, 1'b1});

  // Point arithmetic on the eight symmetric offsets.
  assign cx_e    = {{(EW-COORD_BITS){held_cx[COORD_BITS-1]}}, held_cx};
  assign cy_e    = {{(EW-COORD_BITS){held_cy[COORD_BITS-1]}}, held_cy};
  assign x_e     = EW'(column);
  assign y_e     = EW'(y_off);
  assign a_e     = pt_idx[2] ? y_e : x_e;
  assign b_e     = pt_idx[2] ? x_e : y_e;
  assign px_full = pt_idx[0] ? (cx_e - a_e) : (cx_e + a_e);
  assign py_full = pt_idx[1] ? (cy_e - b_e) : (cy_e + b_e);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_stall = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (item_acc) begin
          if (mode == MODE_START) begin
            state_next = ST_MUL;
          end else if (mode == MODE_ADVANCE && active) begin
            state_next = ST_LOAD;
          end
        end
      end
      ST_MUL: begin
        if (cnt_last_mul) begin
          state_next = ST_PIVOT;
        end
      end
      ST_PIVOT: begin
        if (cnt_last_root) begin
          state_next = ST_PIVSET;
        end
      end
      ST_PIVSET: state_next = ST_LOAD;
      ST_LOAD:   state_next = ST_ROOT;
      ST_ROOT: begin
        if (cnt_last_root) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (emit_go && pt_idx == LAST_POINT) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= '0;
      pt_idx      <= '0;
      active      <= 1'b0;
      point_valid <= 1'b0;
    end else begin
      if (state_next != state) begin
        cnt <= '0;
      end else if (state == ST_MUL || state == ST_PIVOT || state == ST_ROOT) begin
        cnt <= cnt + CNTW'(1);
      end
      if (emit_go) begin
        pt_idx      <= pt_idx + PT_BITS'(1);
        point_valid <= 1'b1;
        if (pt_idx == LAST_POINT) begin
          active <= !col_done;
        end
      end else if (!point_stall) begin
        point_valid <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (item_acc && mode == MODE_START) begin
          held_cx <= centre_x;
          held_cy <= centre_y;
          mcand   <= radius;
          mpl     <= radius;
          r2      <= '0;
        end else if (item_acc && active) begin
          column <= column + INTB'(1);
          col_sq <= sq_inc;
        end
      end
      ST_MUL: begin
        r2  <= r2_next;
        mpl <= {mpl[RADIUS_BITS-2:0], 1'b0};
        if (cnt_last_mul) begin
          rad  <= {1'b0, r2_next, 1'b0};
          rem  <= '0;
          root <= '0;
        end
      end
      ST_PIVOT, ST_ROOT: begin
        rad  <= {rad[RADW-3:0], 2'b00};
        rem  <= trial_ge ? rem_sub : rem_shift;
        root <= {root[ROOT_N-2:0], trial_ge};
      end
      ST_PIVSET: begin
        pivot  <= round_full[INTB-1:0];
        column <= '0;
        col_sq <= '0;
      end
      ST_LOAD: begin
        rad  <= {d_val, 2'b00};
        rem  <= '0;
        root <= '0;
      end
      ST_ROUND: begin
        y_off    <= round_full[YB-1:0];
        col_done <= (column >= pivot);
      end
      ST_EMIT: begin
        if (emit_go) begin
          point_x      <= px_full[OW-1:0];
          point_y      <= py_full[OW-1:0];
          last_of_step <= (pt_idx == LAST_POINT);
          circle_done  <= col_done;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

FILE: hw/rtl/copg_checker.sv
`include "circle_octant_point_generator_core_defines.svh"

module copg_checker
  import copg_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         item_valid,
  input logic                         item_stall,
  input logic                         mode,
  input logic                         point_valid,
  input logic                         point_stall,
  input logic signed [COORD_BITS:0]   point_x,
  input logic signed [COORD_BITS:0]   point_y,
  input logic                         last_of_step,
  input logic                         circle_done
);

  logic                    pt_wait;
  logic                    pt_mid;
  logic                    start_acc;
  logic [2*COORD_BITS+3:0] pt_word;

  // A point is offered and held back by the receiver.
  assign pt_wait   = point_valid && point_stall;
  // A point other than the eighth of its column is taken.
  assign pt_mid    = point_valid && !point_stall && !last_of_step;
  assign start_acc = item_valid && !item_stall && (mode == MODE_START);
  assign pt_word   = {point_x, point_y, last_of_step, circle_done};

  // A point held under stall stays offered and keeps all of its fields.
  `COPG_ASSERT_NEXT(a_hold, pt_wait, point_valid && $stable(pt_word), "held point changed")

  // A start word always keeps the block busy in the following cycle.
  `COPG_ASSERT_NEXT(a_start_busy, start_acc, item_stall, "start word did not occupy the block")

  // No input word is taken while points of the current column remain.
  `COPG_ASSERT_SAME(a_no_take_mid_step, pt_mid, item_stall, "input taken mid column")

  // All points of one column carry the same done flag.
  `COPG_ASSERT_NEXT(a_done, pt_mid, !point_valid || $stable(circle_done), "done flag changed")

endmodule

bind circle_octant_point_generator_core copg_checker #(
  .COORD_BITS (COORD_BITS)
) u_copg_checker (.*);
